>>> rtl/core/prp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prp_pkg;

	// Built frame table and field widths
	localparam int FRAMES      = 8;
	localparam int PAGE_BITS   = 16;
	localparam int FIDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W       = $clog2(FRAMES + 1);
	localparam int STAMP_W     = 32;
	localparam int FRAME_OUT_W = 3;
	localparam int MODE_W      = 2;
	localparam int FIN_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [FIDX_W-1:0]    fidx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [STAMP_W-1:0]   stamp_t;
	typedef logic [MODE_W-1:0]    mode_t;

	// Replacement policy codes
	localparam mode_t MODE_FIFO  = 2'd0;
	localparam mode_t MODE_LRU   = 2'd1;
	localparam mode_t MODE_CLOCK = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SWEEP,
		ST_WRITE,
		ST_DONE
	} prp_state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic decide;
		logic sweep;
		logic write;
		logic load;
	} prp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
		logic go_sweep;
		logic sweep_hit;
		logic out_free;
	} prp_sts_t;

	// Step a frame pointer around the managed range
	function automatic fidx_t next_frame(fidx_t i, cnt_t n);
		cnt_t nxt;
		nxt = cnt_t'(i) + cnt_t'(1);
		return (nxt >= n) ? '0 : fidx_t'(nxt);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/prp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module prp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire prp_pkg::prp_sts_t sts,
	output prp_pkg::prp_cmd_t      cmd
);
	import prp_pkg::*;

	prp_state_t state_q;
	prp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = sts.go_sweep ? ST_SWEEP : ST_WRITE;
			end
			ST_SWEEP: begin
				if (sts.sweep_hit) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid;
			end
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_SWEEP:  cmd.sweep  = 1'b1;
			ST_WRITE:  cmd.write  = 1'b1;
			ST_DONE:   cmd.load   = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

`ifndef SYNTH
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_SCAN))
		else $error("accepted reference did not start a scan");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> (state_q == ST_DONE))
		else $error("result dropped while output register busy");
`endif

endmodule

`default_nettype wire

>>> rtl/core/prp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module prp_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [prp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [prp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [prp_pkg::PAGE_BITS-1:0]    page_number,
	input  wire prp_pkg::prp_cmd_t                cmd,
	output prp_pkg::prp_sts_t                     sts,
	input  wire logic                             rsp_stall,
	output logic                                  rsp_valid,
	output logic                                  hit,
	output logic [prp_pkg::FRAME_OUT_W-1:0]       frame_slot,
	output logic                                  evicted_valid,
	output logic [prp_pkg::PAGE_BITS-1:0]         evicted_page,
	output logic [prp_pkg::STAMP_W-1:0]           hit_total,
	output logic [prp_pkg::STAMP_W-1:0]           fault_total
);
	import prp_pkg::*;

	mode_t              mode_q;
	logic [FIN_W-1:0]   fin_q;
	cnt_t               n;

	page_t              page_mem_q [FRAMES];
	stamp_t             stamp_mem_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	logic [FRAMES-1:0]  ref_q;

	fidx_t              fifo_q;
	fidx_t              hand_q;
	fidx_t              fifo_w;
	fidx_t              hand_w;
	stamp_t             acc_q;
	stamp_t             hits_q;
	stamp_t             faults_q;

	page_t              cur_page_q;
	fidx_t              idx_q;
	logic               found_q;
	fidx_t              hit_idx_q;
	logic               empty_q;
	fidx_t              empty_idx_q;
	stamp_t             min_q;
	fidx_t              min_idx_q;
	fidx_t              target_q;

	logic               res_evv_q;
	page_t              res_evp_q;

	logic               rsp_valid_q;
	logic               hit_q;
	logic [FRAME_OUT_W-1:0] frame_slot_q;
	logic               evicted_valid_q;
	page_t              evicted_page_q;
	stamp_t             hit_total_q;
	stamp_t             fault_total_q;

	fidx_t              rd_idx;
	page_t              rd_page;
	stamp_t             rd_stamp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIFO;
			fin_q  <= FIN_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[MODE_W-1:0];
				REG_FRAMES: fin_q  <= cfg_data[FIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Managed frame count, zero acts as one, clamp at the built size
	always_comb begin
		if (fin_q == '0) begin
			n = cnt_t'(1);
		end else if (int'(fin_q) > FRAMES) begin
			n = cnt_t'(FRAMES);
		end else begin
			n = cnt_t'(fin_q);
		end
	end

	assign fifo_w   = (cnt_t'(fifo_q) >= n) ? '0 : fifo_q;
	assign hand_w   = (cnt_t'(hand_q) >= n) ? '0 : hand_q;
	assign rd_idx   = cmd.write ? target_q : idx_q;
	assign rd_page  = page_mem_q[rd_idx];
	assign rd_stamp = stamp_mem_q[idx_q];

	assign sts.scan_last = (cnt_t'(idx_q) == (n - cnt_t'(1)));
	assign sts.go_sweep  = !found_q && !empty_q && (mode_q == MODE_CLOCK);
	assign sts.sweep_hit = !ref_q[hand_q];
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	// Scan bookkeeping: first hit, first empty frame, least stamp
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_page_q <= page_number;
			idx_q      <= '0;
			found_q    <= 1'b0;
			empty_q    <= 1'b0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + fidx_t'(1);
			if (valid_q[idx_q] && (rd_page == cur_page_q) && !found_q) begin
				found_q   <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!valid_q[idx_q] && !empty_q) begin
				empty_q     <= 1'b1;
				empty_idx_q <= idx_q;
			end
			if ((idx_q == '0) || (rd_stamp < min_q)) begin
				min_q     <= rd_stamp;
				min_idx_q <= idx_q;
			end
		end
	end

	// Victim choice and pointer upkeep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_q <= '0;
			hand_q <= '0;
		end else if (cmd.decide && !found_q) begin
			hand_q <= hand_w;
			if (empty_q) begin
				fifo_q <= (mode_q != MODE_LRU && mode_q != MODE_CLOCK)
					? next_frame(empty_idx_q, n) : fifo_w;
			end else if (mode_q == MODE_LRU || mode_q == MODE_CLOCK) begin
				fifo_q <= fifo_w;
			end else begin
				fifo_q <= next_frame(fifo_w, n);
			end
		end else if (cmd.sweep) begin
			hand_q <= next_frame(hand_q, n);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (found_q) begin
				target_q <= hit_idx_q;
			end else if (empty_q) begin
				target_q <= empty_idx_q;
			end else if (mode_q == MODE_LRU) begin
				target_q <= min_idx_q;
			end else if (mode_q != MODE_CLOCK) begin
				target_q <= fifo_w;
			end
		end else if (cmd.sweep && !ref_q[hand_q]) begin
			target_q <= hand_q;
		end
	end

	// Frame table flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q   <= '0;
		end else if (cmd.sweep && ref_q[hand_q]) begin
			ref_q[hand_q] <= 1'b0;
		end else if (cmd.write) begin
			valid_q[target_q] <= 1'b1;
			ref_q[target_q]   <= 1'b1;
		end
	end

	// Frame table payload and eviction result
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			stamp_mem_q[target_q] <= acc_q;
			if (found_q) begin
				res_evv_q <= 1'b0;
				res_evp_q <= '0;
			end else begin
				page_mem_q[target_q] <= cur_page_q;
				res_evv_q <= !empty_q;
				res_evp_q <= empty_q ? '0 : rd_page;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			hits_q   <= '0;
			faults_q <= '0;
		end else if (cmd.write) begin
			acc_q <= acc_q + stamp_t'(1);
			if (found_q) begin
				hits_q <= hits_q + stamp_t'(1);
			end else begin
				faults_q <= faults_q + stamp_t'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q           <= found_q;
			frame_slot_q    <= FRAME_OUT_W'(target_q);
			evicted_valid_q <= res_evv_q;
			evicted_page_q  <= res_evp_q;
			hit_total_q     <= hits_q;
			fault_total_q   <= faults_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign hit           = hit_q;
	assign frame_slot    = frame_slot_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign hit_total     = hit_total_q;
	assign fault_total   = fault_total_q;

`ifndef SYNTH
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(hits_q + faults_q) == acc_q)
		else $error("hit and fault totals disagree with access count");

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> valid_q[$past(target_q)])
		else $error("written frame not marked valid");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(rsp_valid_q && rsp_stall))
		else $error("output register overwritten while stalled");

	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> (cnt_t'(hand_q) < n))
		else $error("clock hand outside managed frames");
`endif

endmodule

`default_nettype wire

>>> rtl/core/page_replacement_policy.sv
`timescale 1ns / 1ps
`default_nettype none

// Page replacement unit. Each transfer on the req channel is one page reference,
// checked against a table of FRAMES frames; each gives exactly one transfer on the
// rsp channel with hit/fault, the frame now holding the page, the evicted page (if
// any) and wrapping hit and fault totals. On a fault the lowest empty managed
// frame is filled; when none is empty, the victim comes from the policy in
// replacement_mode (0 FIFO pointer, 1 least recently used by access stamp, 2
// second chance clock sweep; 3 acts as FIFO). frames_in_use sets the managed
// frame count n (0 acts as 1, values above FRAMES clamp). The block takes one
// reference at a time: it scans the managed frames, decides, sweeps the clock
// hand in second chance mode (at most n + 1 steps), writes the frame table back
// and loads the result; a result that cannot be loaded because the previous one
// is still stalled waits until the output register is free. The frame scan
// reads one frame per cycle through the single read port of the frame table.
// A new reference is taken while the previous result still waits in the output
// register. Write the configuration port only while idle; cfg_ready is always
// high.
module page_replacement_policy (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [prp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [prp_pkg::CFG_DATA_W-1:0]   cfg_data,
	// page references
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic [prp_pkg::PAGE_BITS-1:0]    page_number,
	// results
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic                                  hit,
	output logic [prp_pkg::FRAME_OUT_W-1:0]       frame_slot,
	output logic                                  evicted_valid,
	output logic [prp_pkg::PAGE_BITS-1:0]         evicted_page,
	output logic [prp_pkg::STAMP_W-1:0]           hit_total,
	output logic [prp_pkg::STAMP_W-1:0]           fault_total
);
	import prp_pkg::*;

	prp_cmd_t cmd;
	prp_sts_t sts;

	// Sequencer: accept, scan, decide, sweep, write back, hand off result
	prp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Frame table, policy pointers, counters and output register
	prp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.page_number   (page_number),
		.cmd           (cmd),
		.sts           (sts),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.hit           (hit),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total)
	);

endmodule

`default_nettype wire

>>> dv/tb_page_replacement_policy.sv
`timescale 1ns / 1ps

module tb_page_replacement_policy;
	import prp_pkg::*;

	// Code 3 is not a named policy; the block treats it as FIFO
	localparam mode_t MODE_SPARE = 2'd3;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_REFS    = 67;
	localparam int POOL_DEPTH    = 12;

	// Frame count written at the start of each random phase; includes zero and
	// values above the built table so the clamping paths get traffic too
	localparam logic [FIN_W-1:0] FRAME_PLAN [RANDOM_PHASES] = '{
		4'd1, 4'd8, 4'd15, 4'd2, 4'd0, 4'd5, 4'd3, 4'd8, 4'd7, 4'd4, 4'd1, 4'd6
	};

	typedef struct packed {
		logic                   hit;
		logic [FRAME_OUT_W-1:0] frame;
		logic                   evicted;
		page_t                  evicted_pg;
		logic [STAMP_W-1:0]     hits;
		logic [STAMP_W-1:0]     faults;
	} page_outcome_t;

	// Block ports; every input starts at a known value
	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index   = '0;
	logic [CFG_DATA_W-1:0]    cfg_data    = '0;
	logic                     req_valid   = 1'b0;
	logic                     req_stall;
	page_t                    page_number = '0;
	logic                     rsp_valid;
	logic                     rsp_stall   = 1'b0;
	logic                     hit;
	logic [FRAME_OUT_W-1:0]   frame_slot;
	logic                     evicted_valid;
	page_t                    evicted_page;
	logic [STAMP_W-1:0]       hit_total;
	logic [STAMP_W-1:0]       fault_total;

	// Mirror of the frame table and policy state
	page_t                    frame_pg    [FRAMES];
	logic                     frame_live  [FRAMES];
	logic [STAMP_W-1:0]       frame_stamp [FRAMES];
	logic                     frame_ref   [FRAMES];
	int                       fifo_ptr;
	int                       hand;
	logic [STAMP_W-1:0]       access_seq;
	logic [STAMP_W-1:0]       hits_so_far;
	logic [STAMP_W-1:0]       faults_so_far;
	mode_t                    policy;
	logic [FIN_W-1:0]         frames_cfg;

	page_t                    pending_pages[$];
	page_outcome_t            expected_outcomes[$];
	page_outcome_t            oldest;

	int                       send_idle_pct = 0;
	int                       recv_idle_pct = 0;
	int                       mismatches    = 0;
	int                       cycle_count   = 0;

	page_replacement_policy dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.page_number   (page_number),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.hit           (hit),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total)
	);

	always #1 clk = ~clk;

	// Advance a frame pointer around the managed range
	function automatic int step_frame(int i, int n);
		return (i + 1 >= n) ? 0 : i + 1;
	endfunction

	// Work out the outcome of one page reference and update the mirror
	function automatic page_outcome_t resolve_reference(page_t pg);
		page_outcome_t      r;
		int                 n;
		int                 tgt;
		int                 i;
		logic               found;
		logic               empty;
		logic               swept;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] least;

		n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
		stamp = access_seq;
		access_seq = access_seq + 1;
		found = 1'b0;
		empty = 1'b0;
		tgt = 0;
		r = '0;

		// Lookup only looks at the managed frames
		for (i = 0; i < n; i++)
			if (!found && frame_live[i] && frame_pg[i] == pg) begin
				found = 1'b1;
				tgt = i;
			end

		if (found) begin
			hits_so_far = hits_so_far + 1;
			frame_stamp[tgt] = stamp;
			frame_ref[tgt] = 1'b1;
		end else begin
			faults_so_far = faults_so_far + 1;
			for (i = 0; i < n; i++)
				if (!empty && !frame_live[i]) begin
					empty = 1'b1;
					tgt = i;
				end
			// Pointers left beyond a shrunken range restart at frame 0
			if (fifo_ptr >= n)
				fifo_ptr = 0;
			if (hand >= n)
				hand = 0;
			if (empty) begin
				if (policy != MODE_LRU && policy != MODE_CLOCK)
					fifo_ptr = step_frame(tgt, n);
			end else if (policy == MODE_LRU) begin
				least = frame_stamp[0];
				tgt = 0;
				for (i = 1; i < n; i++)
					if (frame_stamp[i] < least) begin
						least = frame_stamp[i];
						tgt = i;
					end
			end else if (policy == MODE_CLOCK) begin
				// One full pass clears every bit, so n + 1 steps always find a victim
				swept = 1'b0;
				for (i = 0; i <= n && !swept; i++) begin
					if (frame_ref[hand]) begin
						frame_ref[hand] = 1'b0;
					end else begin
						tgt = hand;
						swept = 1'b1;
					end
					hand = step_frame(hand, n);
				end
			end else begin
				tgt = fifo_ptr;
				fifo_ptr = step_frame(fifo_ptr, n);
			end
			if (!empty) begin
				r.evicted = 1'b1;
				r.evicted_pg = frame_pg[tgt];
			end
			frame_pg[tgt] = pg;
			frame_live[tgt] = 1'b1;
			frame_stamp[tgt] = stamp;
			frame_ref[tgt] = 1'b1;
		end

		r.hit = found;
		r.frame = tgt[FRAME_OUT_W-1:0];
		r.hits = hits_so_far;
		r.faults = faults_so_far;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [STAMP_W-1:0] want,
			input logic [STAMP_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Write one register at a fresh edge; the mirror takes it at the transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MODE)
			policy = mode_t'(val);
		else
			frames_cfg = val;
	endtask

	// Hold until every queued reference has gone through and been answered
	task automatic wait_drained();
		while (pending_pages.size() != 0 || req_valid || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Request driver: predict on each transfer, then load the next page or idle.
	// A held item is never touched while the block stalls it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				expected_outcomes.insert(expected_outcomes.size(),
					resolve_reference(page_number));
			if (!req_valid || !req_stall) begin
				if (pending_pages.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid   <= 1'b1;
					page_number <= pending_pages.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer against the oldest prediction, then
	// pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result with nothing outstanding: hit %0b frame %0d",
						$time, hit, frame_slot);
					mismatches++;
				end else begin
					oldest = expected_outcomes.pop_front();
					compare_field("hit", STAMP_W'(oldest.hit), STAMP_W'(hit));
					compare_field("frame_slot", STAMP_W'(oldest.frame),
						STAMP_W'(frame_slot));
					compare_field("evicted_valid", STAMP_W'(oldest.evicted),
						STAMP_W'(evicted_valid));
					compare_field("evicted_page", STAMP_W'(oldest.evicted_pg),
						STAMP_W'(evicted_page));
					compare_field("hit_total", oldest.hits, hit_total);
					compare_field("fault_total", oldest.faults, fault_total);
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		page_t pool [POOL_DEPTH];
		int    p;
		int    k;
		int    live_n;
		int    span;

		for (k = 0; k < FRAMES; k++) begin
			frame_pg[k]    = '0;
			frame_live[k]  = 1'b0;
			frame_stamp[k] = '0;
			frame_ref[k]   = 1'b0;
		end
		fifo_ptr      = 0;
		hand          = 0;
		access_seq    = '0;
		hits_so_far   = '0;
		faults_so_far = '0;
		policy        = MODE_FIFO;
		frames_cfg    = 4'd8;
		send_idle_pct = 7;
		recv_idle_pct = 46;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// FIFO over two frames: extreme page numbers, a hit, a pointer eviction
		write_reg(REG_MODE, {2'b00, MODE_FIFO});
		write_reg(REG_FRAMES, 4'd2);
		@(negedge clk);
		pending_pages = '{16'h0000, 16'hffff, 16'h0000, 16'h0005, 16'hffff};
		wait_drained();

		// LRU: grow to three frames, fill the new empty frame, then evict the
		// least recently used one
		write_reg(REG_MODE, {2'b00, MODE_LRU});
		write_reg(REG_FRAMES, 4'd3);
		@(negedge clk);
		pending_pages = '{16'h0007, 16'h0005, 16'hffff, 16'h0009};
		wait_drained();

		// Second chance with an oversized frame count: fill the rest of the
		// table, then force a full sweep that clears every reference bit
		write_reg(REG_MODE, {2'b00, MODE_CLOCK});
		write_reg(REG_FRAMES, 4'd15);
		@(negedge clk);
		pending_pages = '{16'h000a, 16'h000b, 16'h000c, 16'h000d, 16'h000e,
			16'h00f1, 16'h00f2};
		wait_drained();

		// Zero frames acts as one, spare mode acts as FIFO, and the stale FIFO
		// pointer must restart at frame 0
		write_reg(REG_MODE, {2'b00, MODE_SPARE});
		write_reg(REG_FRAMES, 4'd0);
		@(negedge clk);
		pending_pages = '{16'h1234, 16'h1234, 16'h4321};
		wait_drained();

		// Widen again: pages parked above the old range must hit
		write_reg(REG_MODE, {2'b00, MODE_FIFO});
		write_reg(REG_FRAMES, 4'd8);
		@(negedge clk);
		pending_pages = '{16'h000e, 16'h000b};
		wait_drained();

		// Random phases: each with its own policy, frame count and working set.
		// The working set is a few pages wider than the table so hits and
		// evictions both happen; some references are fully random noise.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p / 4)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// Random upper data bits on the mode write; only the low bits count
			write_reg(REG_MODE, {2'($urandom), mode_t'(p % 4)});
			write_reg(REG_FRAMES, FRAME_PLAN[p]);
			live_n = (FRAME_PLAN[p] == 0) ? 1 :
				(FRAME_PLAN[p] > FRAMES) ? FRAMES : int'(FRAME_PLAN[p]);
			span = (live_n + 3 < POOL_DEPTH) ? live_n + 3 : POOL_DEPTH - 1;
			for (k = 0; k < POOL_DEPTH; k++)
				pool[k] = page_t'($urandom);
			@(negedge clk);
			for (k = 0; k < PHASE_REFS; k++) begin
				if ($urandom_range(99) < 85)
					pending_pages.insert(pending_pages.size(),
						pool[$urandom_range(span, 0)]);
				else
					pending_pages.insert(pending_pages.size(), page_t'($urandom));
			end
			wait_drained();
		end

		// Give the block time to show any stray result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
